FILE: src/bef_pkg.sv
package bef_pkg;

    localparam int DEF_MAX_NODES  = 64;
    localparam int DEF_MAX_DEGREE = 8;

    localparam int KIND_W   = 2;
    localparam int NODE_W   = 6;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic [5:0]       MAX_REPORTS    = 6'd63;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_BRIDGE   = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_NONE     = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD1,
        S_ADD2,
        S_CLR,
        S_ROOT,
        S_DEG,
        S_EDGE,
        S_ADJ,
        S_BACK,
        S_POP,
        S_FIN
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic              last;
    } res_t;

endpackage

FILE: src/bef_ifs.sv
interface bef_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [bef_pkg::KIND_W-1:0] kind;
    logic [bef_pkg::NODE_W-1:0] node_a;
    logic [bef_pkg::NODE_W-1:0] node_b;

    modport source (output valid, kind, node_a, node_b, input ready);
    modport sink (input valid, kind, node_a, node_b, output ready);
endinterface

interface bef_res_if;
    logic                         valid;
    logic                         ready;
    logic [bef_pkg::STATUS_W-1:0] status;
    logic [bef_pkg::NODE_W-1:0]   from_node;
    logic [bef_pkg::NODE_W-1:0]   to_node;
    logic                         last;

    modport source (output valid, status, from_node, to_node, last, input ready);
    modport sink (input valid, status, from_node, to_node, last, output ready);
endinterface

interface bef_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [bef_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: src/bridge_edge_finder_core.sv
// channel | dir | payload                                 | beat when
// cmd     | in  | kind, node_a, node_b                    | valid & ready
// res     | out | status, from_node, to_node, last        | valid & ready
// cfg     | in  | data = node_count                       | valid & ready
//
// add edge: degree read, then one write-back per endpoint when accepted; a dropped edge skips the write-backs.
// clear: drops every degree valid bit and returns one cleared result. run: the adjacency
// and stack memories each have a single read port.
// reset clears control state and degree valid bits; no clearing pass.
// result register decouples res.ready; a full result stalls the search.
module bridge_edge_finder_core #(
    parameter int MAX_NODES  = bef_pkg::DEF_MAX_NODES,
    parameter int MAX_DEGREE = bef_pkg::DEF_MAX_DEGREE
) (
    input logic   clk,
    input logic   rst_n,
    bef_cmd_if.sink   cmd,
    bef_res_if.source res,
    bef_cfg_if.sink   cfg
);
    import bef_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int XW  = (NCW > CFG_W) ? NCW : CFG_W;
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int AD  = MAX_NODES * MAX_DEGREE;
    localparam int AW  = $clog2(AD);

    typedef struct packed {
        logic [NW-1:0] node;
        logic [NW-1:0] par;
        logic          haspar;
        logic [DW-1:0] pos;
        logic [DW-1:0] deg;
        logic [NW-1:0] disc;
        logic [NW-1:0] low;
    } frame_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    ncnt_reg;
    frame_t              top_reg, top_next;
    logic [NW-1:0]       d_reg, d_next;
    logic [NCW-1:0]      order_reg, order_next;
    logic [NCW-1:0]      root_reg, root_next;
    logic [MAX_NODES-1:0] vis_reg, vis_next;
    logic [MAX_NODES-1:0] dvld_reg, dvld_next;
    logic [5:0]          rcnt_reg, rcnt_next;
    logic                pend_v_reg, pend_v_next;
    logic [NW-1:0]       pend_from_reg, pend_from_next;
    logic [NW-1:0]       pend_to_reg, pend_to_next;
    logic [NW-1:0]       w_reg, w_next;
    logic [NW-1:0]       cl_reg, cl_next;
    logic [NODE_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [DW-1:0]       dsave_reg, dsave_next;
    logic                o_valid_reg;
    res_t                o_data_reg;

    logic                emit;
    res_t                emit_data;
    logic                slot_free;
    logic                rep;
    logic [NW-1:0]       rep_from, rep_to;

    // memories
    logic [NW-1:0]  adj_mem [AD];
    logic [DW-1:0]  deg_mem [MAX_NODES];
    logic [NW-1:0]  disc_mem [MAX_NODES];
    logic [NW-1:0]  low_mem [MAX_NODES];
    frame_t         stk_mem [MAX_NODES];

    logic           adj_we;
    logic [AW-1:0]  adj_wa, adj_ra;
    logic [NW-1:0]  adj_wd, adj_q;
    logic           deg_we;
    logic [NW-1:0]  deg_wa, deg_ra_a, deg_ra_b;
    logic [DW-1:0]  deg_wd, deg_qa, deg_qb;
    logic           dv_qa, dv_qb;
    logic           disc_we;
    logic [NW-1:0]  disc_wa, disc_wd, disc_q;
    logic           low_we;
    logic [NW-1:0]  low_wa, low_wd, low_q;
    logic [NW-1:0]  dl_ra;
    logic           stk_we;
    logic [NW-1:0]  stk_wa, stk_ra;
    frame_t         stk_wd, stk_q;

    logic [XW-1:0]  n_x;
    logic [DW-1:0]  deg_a, deg_b;
    logic           in_rng, add_ok;
    logic [NW-1:0]  dw, lw, newlow;
    frame_t         f;

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_wa] <= adj_wd;
        end
        adj_q <= adj_mem[adj_ra];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_wa] <= deg_wd;
        end
        deg_qa <= deg_mem[deg_ra_a];
        deg_qb <= deg_mem[deg_ra_b];
        dv_qa  <= dvld_reg[deg_ra_a];
        dv_qb  <= dvld_reg[deg_ra_b];
    end

    always_ff @(posedge clk)
    begin
        if (disc_we)
        begin
            disc_mem[disc_wa] <= disc_wd;
        end
        disc_q <= disc_mem[dl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (low_we)
        begin
            low_mem[low_wa] <= low_wd;
        end
        low_q <= low_mem[dl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_q <= stk_mem[stk_ra];
    end

    assign n_x = (XW'(ncnt_reg) > XW'(MAX_NODES)) ? XW'(MAX_NODES) : XW'(ncnt_reg);
    assign deg_a = dv_qa ? deg_qa : '0;
    assign deg_b = dv_qb ? deg_qb : '0;
    assign slot_free = !o_valid_reg || res.ready;

    assign in_rng = (XW'(a_reg) < n_x) && (XW'(b_reg) < n_x);
    always_comb
    begin
        if (a_reg == b_reg)
        begin
            add_ok = in_rng
                && ((DW + 1)'(deg_a) + (DW + 1)'(2) <= (DW + 1)'(MAX_DEGREE));
        end
        else
        begin
            add_ok = in_rng && (deg_a < DW'(MAX_DEGREE)) && (deg_b < DW'(MAX_DEGREE));
        end
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        d_next         = d_reg;
        order_next     = order_reg;
        root_next      = root_reg;
        vis_next       = vis_reg;
        dvld_next      = dvld_reg;
        rcnt_next      = rcnt_reg;
        pend_v_next    = pend_v_reg;
        pend_from_next = pend_from_reg;
        pend_to_next   = pend_to_reg;
        w_next         = w_reg;
        cl_next        = cl_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        dsave_next     = dsave_reg;
        emit           = 1'b0;
        emit_data      = '0;
        rep            = 1'b0;
        rep_from       = '0;
        rep_to         = '0;
        adj_we   = 1'b0;
        adj_wa   = '0;
        adj_wd   = '0;
        adj_ra   = '0;
        deg_we   = 1'b0;
        deg_wa   = '0;
        deg_wd   = '0;
        deg_ra_a = '0;
        deg_ra_b = '0;
        disc_we  = 1'b0;
        disc_wa  = '0;
        disc_wd  = '0;
        low_we   = 1'b0;
        low_wa   = '0;
        low_wd   = '0;
        dl_ra    = '0;
        stk_we   = 1'b0;
        stk_wa   = '0;
        stk_wd   = '0;
        stk_ra   = '0;
        dw       = '0;
        lw       = '0;
        newlow   = '0;
        f        = stk_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    a_next = cmd.node_a;
                    b_next = cmd.node_b;
                    unique case (kind_t'(cmd.kind))
                        KIND_ADD:
                        begin
                            deg_ra_a   = NW'(cmd.node_a);
                            deg_ra_b   = NW'(cmd.node_b);
                            state_next = S_ADD1;
                        end
                        KIND_RUN:
                        begin
                            vis_next    = '0;
                            order_next  = '0;
                            root_next   = '0;
                            rcnt_next   = '0;
                            pend_v_next = 1'b0;
                            d_next      = '0;
                            state_next  = S_ROOT;
                        end
                        KIND_CLEAR:
                        begin
                            dvld_next  = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                if (slot_free)
                begin
                    emit             = 1'b1;
                    emit_data.status = ST_CLEARED;
                    emit_data.last   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_ADD1:
            begin
                // keep the degree reads on the endpoints while stalled
                deg_ra_a = NW'(a_reg);
                deg_ra_b = NW'(b_reg);
                if (add_ok)
                begin
                    adj_we = 1'b1;
                    adj_wa = AW'(AW'(NW'(a_reg)) * AW'(MAX_DEGREE) + AW'(deg_a));
                    adj_wd = NW'(b_reg);
                    deg_we = 1'b1;
                    deg_wa = NW'(a_reg);
                    deg_wd = deg_a + DW'(1);
                    dvld_next[NW'(a_reg)] = 1'b1;
                    dsave_next = (a_reg == b_reg) ? deg_a + DW'(1) : deg_b;
                    state_next = S_ADD2;
                end
                else if (slot_free)
                begin
                    emit             = 1'b1;
                    emit_data.status = ST_DROPPED;
                    emit_data.last   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_ADD2:
            begin
                if (slot_free)
                begin
                    adj_we = 1'b1;
                    adj_wa = AW'(AW'(NW'(b_reg)) * AW'(MAX_DEGREE) + AW'(dsave_reg));
                    adj_wd = NW'(a_reg);
                    deg_we = 1'b1;
                    deg_wa = NW'(b_reg);
                    deg_wd = dsave_reg + DW'(1);
                    dvld_next[NW'(b_reg)] = 1'b1;
                    emit             = 1'b1;
                    emit_data.status = ST_ACCEPTED;
                    emit_data.last   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (XW'(root_reg) >= n_x)
                begin
                    state_next = S_FIN;
                end
                else if (vis_reg[NW'(root_reg)])
                begin
                    root_next = root_reg + NCW'(1);
                end
                else
                begin
                    top_next.node   = NW'(root_reg);
                    top_next.par    = '0;
                    top_next.haspar = 1'b0;
                    top_next.pos    = '0;
                    top_next.deg    = '0;
                    top_next.disc   = NW'(order_reg);
                    top_next.low    = NW'(order_reg);
                    order_next      = order_reg + NCW'(1);
                    vis_next[NW'(root_reg)] = 1'b1;
                    disc_we    = 1'b1;
                    disc_wa    = NW'(root_reg);
                    disc_wd    = NW'(order_reg);
                    deg_ra_a   = NW'(root_reg);
                    root_next  = root_reg + NCW'(1);
                    state_next = S_DEG;
                end
            end
            S_DEG:
            begin
                top_next.deg = deg_a;
                state_next   = S_EDGE;
            end
            S_EDGE:
            begin
                if (top_reg.pos < top_reg.deg)
                begin
                    adj_ra = AW'(AW'(top_reg.node) * AW'(MAX_DEGREE) + AW'(top_reg.pos));
                    top_next.pos = top_reg.pos + DW'(1);
                    state_next   = S_ADJ;
                end
                else
                begin
                    // node finished: its low-link is final
                    low_we = 1'b1;
                    low_wa = top_reg.node;
                    low_wd = top_reg.low;
                    if (d_reg != '0)
                    begin
                        stk_ra     = d_reg - NW'(1);
                        d_next     = d_reg - NW'(1);
                        w_next     = top_reg.node;
                        cl_next    = top_reg.low;
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_ROOT;
                    end
                end
            end
            S_ADJ:
            begin
                w_next = adj_q;
                if ((XW'(adj_q) >= n_x) || (top_reg.haspar && adj_q == top_reg.par))
                begin
                    state_next = S_EDGE;
                end
                else if (!vis_reg[adj_q])
                begin
                    stk_we = 1'b1;
                    stk_wa = d_reg;
                    stk_wd = top_reg;
                    d_next = d_reg + NW'(1);
                    low_we = 1'b1;
                    low_wa = top_reg.node;
                    low_wd = top_reg.low;
                    top_next.node   = adj_q;
                    top_next.par    = top_reg.node;
                    top_next.haspar = 1'b1;
                    top_next.pos    = '0;
                    top_next.deg    = '0;
                    top_next.disc   = NW'(order_reg);
                    top_next.low    = NW'(order_reg);
                    order_next      = order_reg + NCW'(1);
                    vis_next[adj_q] = 1'b1;
                    disc_we    = 1'b1;
                    disc_wa    = adj_q;
                    disc_wd    = NW'(order_reg);
                    deg_ra_a   = adj_q;
                    state_next = S_DEG;
                end
                else
                begin
                    dl_ra      = adj_q;
                    state_next = S_BACK;
                end
            end
            S_BACK:
            begin
                dl_ra = w_reg;
                if (slot_free)
                begin
                    dw     = (w_reg == top_reg.node) ? top_reg.disc : disc_q;
                    newlow = (dw < top_reg.low) ? dw : top_reg.low;
                    // self loop sees the freshly lowered value of its own node
                    lw     = (w_reg == top_reg.node) ? newlow : low_q;
                    top_next.low = newlow;
                    if (top_reg.disc < lw)
                    begin
                        rep      = 1'b1;
                        rep_from = top_reg.node;
                        rep_to   = w_reg;
                    end
                    state_next = S_EDGE;
                end
            end
            S_POP:
            begin
                stk_ra = d_reg;
                if (slot_free)
                begin
                    top_next     = f;
                    top_next.low = (cl_reg < f.low) ? cl_reg : f.low;
                    if (f.disc < cl_reg)
                    begin
                        rep      = 1'b1;
                        rep_from = f.node;
                        rep_to   = w_reg;
                    end
                    state_next = S_EDGE;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_data.last = 1'b1;
                    if (pend_v_reg)
                    begin
                        emit_data.status    = ST_BRIDGE;
                        emit_data.from_node = NODE_W'(pend_from_reg);
                        emit_data.to_node   = NODE_W'(pend_to_reg);
                    end
                    else
                    begin
                        emit_data.status = ST_NONE;
                    end
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hold one report back so the final one can carry last
        if (rep && rcnt_reg != MAX_REPORTS)
        begin
            rcnt_next      = rcnt_reg + 6'd1;
            pend_v_next    = 1'b1;
            pend_from_next = rep_from;
            pend_to_next   = rep_to;
            if (pend_v_reg)
            begin
                emit                = 1'b1;
                emit_data.status    = ST_BRIDGE;
                emit_data.from_node = NODE_W'(pend_from_reg);
                emit_data.to_node   = NODE_W'(pend_to_reg);
                emit_data.last      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ncnt_reg    <= NODE_COUNT_RST;
            d_reg       <= '0;
            order_reg   <= '0;
            root_reg    <= '0;
            vis_reg     <= '0;
            dvld_reg    <= '0;
            rcnt_reg    <= '0;
            pend_v_reg  <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            d_reg      <= d_next;
            order_reg  <= order_next;
            root_reg   <= root_next;
            vis_reg    <= vis_next;
            dvld_reg   <= dvld_next;
            rcnt_reg   <= rcnt_next;
            pend_v_reg <= pend_v_next;
            if (cfg.valid)
            begin
                ncnt_reg <= cfg.data;
            end
            if (emit)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        w_reg         <= w_next;
        cl_reg        <= cl_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        dsave_reg     <= dsave_next;
        pend_from_reg <= pend_from_next;
        pend_to_reg   <= pend_to_next;
        if (emit)
        begin
            o_data_reg <= emit_data;
        end
    end

    assign res.valid     = o_valid_reg;
    assign res.status    = o_data_reg.status;
    assign res.from_node = o_data_reg.from_node;
    assign res.to_node   = o_data_reg.to_node;
    assign res.last      = o_data_reg.last;

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_v_reg)
        else $error("held report left over after a run");

    a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EDGE |-> vis_reg[top_reg.node])
        else $error("search top node not marked visited");

    a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EDGE |-> NCW'(d_reg) < order_reg)
        else $error("stack deeper than discovered nodes");

    a_pop_after_edge: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> $past(state_reg) == S_EDGE || $past(state_reg) == S_POP)
        else $error("pop without finished node");

endmodule

FILE: tb/sv/bef_tb_ifs_placeholder.sv
`timescale 1ns / 100ps

// shared beat record used by the bench
package bef_tb_pkg;
    import bef_pkg::*;

    typedef struct {
        kind_t      kind;
        logic [5:0] node_a;
        logic [5:0] node_b;
        logic       has_exp;
        status_t    exp_status;
    } cmd_row_t;
endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bef_pkg::*;
    import bef_tb_pkg::*;

    localparam int NODES  = 64;
    localparam int DEGREE = 8;

    logic clk;
    logic rst_n;

    bef_cmd_if cmd();
    bef_res_if res();
    bef_cfg_if cfg();

    bridge_edge_finder_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg)
    );

    // graph mirror
    logic [6:0] node_count;
    logic [5:0] adj [NODES*DEGREE];
    int         deg [NODES];
    bit         seen [NODES];
    int         disc [NODES];
    int         lowl [NODES];
    int         order_ctr;
    int         n_reports;

    res_t expected_results [$];

    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int n_items;
    int n_bridges;
    int n_runs;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #200ms;
        $display("timeout at %0t", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic res_t make_res(status_t st, logic [5:0] f, logic [5:0] t, logic l);
        res_t r;
        r.status = st;
        r.from_node = f;
        r.to_node = t;
        r.last = l;
        return r;
    endfunction

    function automatic void queue_result(res_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic void add_bridge(int p, int c);
        if (n_reports < 63)
        begin
            queue_result(make_res(ST_BRIDGE, p[5:0], c[5:0], 1'b0));
            n_reports++;
        end
    endfunction

    function automatic void mark_seen(int v);
        disc[v] = order_ctr;
        lowl[v] = order_ctr;
        order_ctr++;
        seen[v] = 1'b1;
    endfunction

    function automatic void walk_from(int root, int n);
        int st_node [NODES+1];
        int st_par [NODES+1];
        int st_pos [NODES+1];
        int sp;
        int cur;
        int w;
        int p;
        mark_seen(root);
        st_node[0] = root;
        st_par[0] = -1;
        st_pos[0] = 0;
        sp = 1;
        while (sp > 0)
        begin
            cur = st_node[sp-1];
            if (st_pos[sp-1] < deg[cur] && st_pos[sp-1] < DEGREE)
            begin
                w = adj[cur*DEGREE + st_pos[sp-1]];
                st_pos[sp-1]++;
                if (w >= n) continue;
                if (st_par[sp-1] == w) continue;
                if (!seen[w])
                begin
                    if (sp > NODES) continue;
                    mark_seen(w);
                    st_node[sp] = w;
                    st_par[sp] = cur;
                    st_pos[sp] = 0;
                    sp++;
                end
                else
                begin
                    if (disc[w] < lowl[cur]) lowl[cur] = disc[w];
                    if (disc[cur] < lowl[w]) add_bridge(cur, w);
                end
            end
            else
            begin
                sp--;
                p = st_par[sp];
                if (p != -1)
                begin
                    if (lowl[cur] < lowl[p]) lowl[p] = lowl[cur];
                    if (disc[p] < lowl[cur]) add_bridge(p, cur);
                end
            end
        end
    endfunction

    // predicts the results of one accepted command
    function automatic void predict_bridges(kind_t k, int a, int b);
        int n;
        bit ok;
        status_t add_st;
        n = (node_count > NODES) ? NODES : node_count;
        case (k)
            KIND_ADD:
            begin
                ok = (a < n) && (b < n);
                if (ok)
                    ok = (a == b) ? (deg[a] + 2 <= DEGREE)
                                  : (deg[a] < DEGREE && deg[b] < DEGREE);
                if (ok)
                begin
                    adj[a*DEGREE + deg[a]] = b[5:0];
                    deg[a]++;
                    adj[b*DEGREE + deg[b]] = a[5:0];
                    deg[b]++;
                end
                if (ok)
                    add_st = ST_ACCEPTED;
                else
                    add_st = ST_DROPPED;
                queue_result(make_res(add_st, '0, '0, 1'b1));
            end
            KIND_CLEAR:
            begin
                foreach (deg[i]) deg[i] = 0;
                queue_result(make_res(ST_CLEARED, '0, '0, 1'b1));
            end
            KIND_RUN:
            begin
                foreach (seen[i]) seen[i] = 1'b0;
                order_ctr = 0;
                n_reports = 0;
                n_runs++;
                for (int i = 0; i < n; i++)
                    if (!seen[i]) walk_from(i, n);
                n_bridges += n_reports;
                if (n_reports == 0)
                    queue_result(make_res(ST_NONE, '0, '0, 1'b1));
                else
                    expected_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = make_res(status_t'(res.status), res.from_node, res.to_node, res.last);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.from_node !== want.from_node ||
                    got.to_node !== want.to_node || got.last !== want.last)
                begin
                    $display("%0t: expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        res.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // valid stays up after the beat; the next call or the caller drops it
    task automatic send_cmd(kind_t k, logic [5:0] a, logic [5:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.kind <= k;
        cmd.node_a <= a;
        cmd.node_b <= b;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        predict_bridges(k, a, b);
        if (k != KIND_NONE) n_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_node_count(logic [6:0] v);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        node_count = v;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // mostly small random graphs, so bridges and cycles both show up
    task automatic random_graph(int items, int span);
        int a;
        int b;
        for (int i = 0; i < items; i++)
        begin
            a = $urandom_range(span - 1);
            b = ($urandom_range(3) == 0) ? a : $urandom_range(span - 1);
            case ($urandom_range(19))
                0: send_cmd(KIND_CLEAR, 6'($urandom), 6'($urandom));
                1: send_cmd(KIND_NONE, 6'($urandom), 6'($urandom));
                2, 3: send_cmd(KIND_RUN, 6'($urandom), 6'($urandom));
                4: send_cmd(KIND_ADD, 6'($urandom), 6'($urandom));
                default: send_cmd(KIND_ADD, a[5:0], b[5:0]);
            endcase
        end
        send_cmd(KIND_RUN, 6'd0, 6'd0);
    endtask

    cmd_row_t directed [] = '{
        '{KIND_RUN,   6'd0,  6'd0,  1'b1, ST_NONE},
        '{KIND_ADD,   6'd0,  6'd63, 1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd63, 6'd63, 1'b1, ST_ACCEPTED},
        '{KIND_RUN,   6'd0,  6'd0,  1'b0, ST_NONE},
        '{KIND_ADD,   6'd1,  6'd2,  1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd2,  6'd3,  1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd3,  6'd1,  1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd3,  6'd4,  1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd3,  6'd4,  1'b1, ST_ACCEPTED},
        '{KIND_NONE,  6'd63, 6'd63, 1'b0, ST_NONE},
        '{KIND_RUN,   6'd0,  6'd0,  1'b0, ST_NONE},
        '{KIND_ADD,   6'd5,  6'd5,  1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd5,  6'd5,  1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd5,  6'd5,  1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd5,  6'd5,  1'b1, ST_ACCEPTED},
        '{KIND_ADD,   6'd5,  6'd5,  1'b1, ST_DROPPED},
        '{KIND_ADD,   6'd5,  6'd6,  1'b1, ST_DROPPED},
        '{KIND_RUN,   6'd0,  6'd0,  1'b0, ST_NONE},
        '{KIND_CLEAR, 6'd42, 6'd21, 1'b1, ST_CLEARED},
        '{KIND_RUN,   6'd0,  6'd0,  1'b1, ST_NONE}
    };

    initial
    begin
        clk = 1'b0;
        errors = 0;
        n_items = 0;
        n_bridges = 0;
        n_runs = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        node_count = NODE_COUNT_RST;
        foreach (deg[i]) deg[i] = 0;
        foreach (adj[i]) adj[i] = '0;
        cmd.valid = 1'b0;
        cmd.kind = KIND_NONE;
        cmd.node_a = '0;
        cmd.node_b = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        res.ready = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            send_cmd(directed[i].kind, directed[i].node_a, directed[i].node_b);
            // typed-in status must agree with the mirror too
            if (directed[i].has_exp && expected_results.size() != 0 &&
                expected_results[$].status != directed[i].exp_status)
            begin
                $display("%0t: expected %s, actual prediction %s", $time,
                         directed[i].exp_status.name(), expected_results[$].status.name());
                errors++;
            end
        end

        // smallest count: endpoint 1 out of range, stale neighbors skipped
        write_node_count(7'd1);
        send_cmd(KIND_ADD, 6'd0, 6'd1);
        send_cmd(KIND_ADD, 6'd0, 6'd0);
        send_cmd(KIND_RUN, 6'd0, 6'd0);
        write_node_count(7'd127);
        send_cmd(KIND_RUN, 6'd0, 6'd0);
        write_node_count(7'd0);
        send_cmd(KIND_ADD, 6'd0, 6'd0);
        send_cmd(KIND_RUN, 6'd0, 6'd0);
        write_node_count(7'd64);
        send_cmd(KIND_CLEAR, 6'd0, 6'd0);

        // long path: many bridges in one run
        for (int i = 0; i < 30; i++)
            send_cmd(KIND_ADD, i[5:0], 6'(i + 1));
        // receiver holds off while commands keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                send_cmd(KIND_RUN, 6'd0, 6'd0);
                send_cmd(KIND_ADD, 6'd50, 6'd51);
                send_cmd(KIND_ADD, 6'd51, 6'd52);
                send_cmd(KIND_RUN, 6'd0, 6'd0);
                cmd.valid <= 1'b0;
            end
        join
        send_cmd(KIND_CLEAR, 6'd0, 6'd0);

        write_node_count(7'd8);
        random_graph(10, 8);
        send_idle_pct = 47;
        write_node_count(7'd12);
        send_cmd(KIND_CLEAR, 6'd0, 6'd0);
        random_graph(10, 12);
        send_idle_pct = 0;
        recv_stall_pct = 47;
        write_node_count(7'd64);
        send_cmd(KIND_CLEAR, 6'd0, 6'd0);
        random_graph(10, 20);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        write_node_count(7'd6);
        send_cmd(KIND_CLEAR, 6'd0, 6'd0);
        random_graph(10, 7);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("covered %0d commands over %0d searches, %0d bridges predicted",
                 n_items, n_runs, n_bridges);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
